// ===== design/lgs_pkg.sv =====
// shared types and constants for the life generation step block
package lgs_pkg;

	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;

	localparam int CFG_DATA_W  = 7;
	localparam int CFG_INDEX_W = 1;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int ROW_W       = $clog2(MAX_HEIGHT + 2);
	localparam int POS_W       = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 1);
	localparam int WIN_W       = 9;
	localparam int CNT_W       = 4;

	localparam int BIRTH_COUNT   = 3;
	localparam int SURVIVE_COUNT = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_BOARD_WIDTH  = 1'b0,
		CFG_BOARD_HEIGHT = 1'b1
	} lgs_cfg_idx_t;

	typedef struct packed {
		logic mode;
		logic cell_alive;
	} lgs_item_t;

	typedef struct packed {
		logic             next_alive;
		logic [CNT_W-1:0] live_neighbors;
		logic             last_of_frame;
	} lgs_result_t;

	// one stage of the two row delay lines
	typedef struct packed {
		logic mid;
		logic up;
	} lgs_cell_data_t;

	typedef struct packed {
		logic shift;
		logic load;
	} lgs_cell_ctrl_t;

	typedef struct packed {
		logic advance;
		logic clear;
		logic row_start;
	} lgs_win_ctrl_t;

endpackage

// ===== design/life_generation_step.sv =====
// top level: conway life b3/s23 generation step over a streamed raster board
// result: the result for a cell is computed with the item width+1 positions later
//   and is registered in the output register, or the skid stage while the output stalls
// throughput: one item per cycle unless item_stall is high; the row delay chain shifts once per item
// reset: width and height go to 64, stream position and window clear; the chain
//   content is not cleared, rows not yet written in a frame read as dead
module life_generation_step (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  lgs_pkg::lgs_item_t            item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output lgs_pkg::lgs_result_t          result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  lgs_pkg::lgs_cfg_idx_t         cfg_index,
	input  logic [lgs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lgs_pkg::*;

	logic [CFG_DATA_W-1:0] width_q;
	logic [CFG_DATA_W-1:0] height_q;
	logic [CFG_DATA_W-1:0] w_eff;
	logic [CFG_DATA_W-1:0] h_eff;
	logic [COL_W-1:0]      w_m1;
	logic [POS_W-1:0]      total;
	logic [POS_W-1:0]      w_ext;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [POS_W-1:0] pos_q;

	logic cfg_fire;
	logic acc;
	logic cell_bit;
	logic mid_bit;
	logic up_bit;
	logic produce;
	logic last_hit;
	logic col_end;

	lgs_cell_data_t chain_data [MAX_WIDTH];
	lgs_cell_data_t head;
	lgs_win_ctrl_t  win_ctrl;
	lgs_result_t    res;
	lgs_result_t    skid_q;
	lgs_result_t    out_q;
	logic           skid_valid_q;
	logic           out_valid_q;
	logic           out_free;
	logic [CNT_W-1:0] nb_count;
	logic           nb_next;

	// board size, out-of-range values saturate
	assign w_eff = (width_q == '0) ? CFG_DATA_W'(1) :
		(width_q > CFG_DATA_W'(MAX_WIDTH)) ? CFG_DATA_W'(MAX_WIDTH) : width_q;
	assign h_eff = (height_q == '0) ? CFG_DATA_W'(1) :
		(height_q > CFG_DATA_W'(MAX_HEIGHT)) ? CFG_DATA_W'(MAX_HEIGHT) : height_q;
	assign w_m1  = COL_W'(w_eff - CFG_DATA_W'(1));
	assign w_ext = POS_W'(w_eff);
	assign total = POS_W'(w_eff) * POS_W'(h_eff);

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid & cfg_ready;

	// a size write restarts the frame, so no cell transaction goes with it
	assign item_stall = skid_valid_q | cfg_valid;
	assign acc        = item_valid & ~item_stall;

	assign cell_bit = (pos_q < total) && !item.mode && item.cell_alive;
	assign mid_bit  = (row_q >= ROW_W'(1)) && chain_data[0].mid;
	assign up_bit   = (row_q >= ROW_W'(2)) && chain_data[0].up;
	assign col_end  = (col_q == w_m1);

	assign produce  = pos_q >= (w_ext + POS_W'(1));
	assign last_hit = produce && (pos_q == total + w_ext);

	// new column enters at stage width-1, oldest column leaves at stage 0
	assign head.mid = cell_bit;
	assign head.up  = chain_data[0].mid;

	for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_chain
		localparam logic [COL_W-1:0] K = COL_W'(k);
		lgs_cell_ctrl_t ctrl;
		lgs_cell_data_t nb;

		assign ctrl.shift = acc & ~cfg_fire;
		assign ctrl.load  = (w_m1 == K);
		if (k == MAX_WIDTH - 1) begin : g_tail
			assign nb = '0;
		end else begin : g_mid
			assign nb = chain_data[k+1];
		end

		lgs_line_cell u_cell (
			.clk  (clk),
			.ctrl (ctrl),
			.head (head),
			.nb   (nb),
			.data (chain_data[k])
		);
	end

	assign win_ctrl.advance   = acc & ~cfg_fire & ~last_hit;
	assign win_ctrl.clear     = cfg_fire | (acc & last_hit);
	assign win_ctrl.row_start = (col_q == '0);

	lgs_window u_window (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (win_ctrl),
		.col            ({cell_bit, mid_bit, up_bit}),
		.live_neighbors (nb_count),
		.next_alive     (nb_next)
	);

	assign res.next_alive     = nb_next;
	assign res.live_neighbors = nb_count;
	assign res.last_of_frame  = last_hit;

	// stream position and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_DATA_W'(MAX_WIDTH);
			height_q <= CFG_DATA_W'(MAX_HEIGHT);
			col_q    <= '0;
			row_q    <= '0;
			pos_q    <= '0;
		end else if (cfg_fire) begin
			unique case (cfg_index)
				CFG_BOARD_WIDTH:  width_q  <= cfg_data;
				CFG_BOARD_HEIGHT: height_q <= cfg_data;
				default:          width_q  <= width_q;
			endcase
			col_q <= '0;
			row_q <= '0;
			pos_q <= '0;
		end else if (acc) begin
			if (last_hit) begin
				col_q <= '0;
				row_q <= '0;
				pos_q <= '0;
			end else begin
				col_q <= col_end ? '0 : col_q + COL_W'(1);
				row_q <= col_end ? row_q + ROW_W'(1) : row_q;
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	// output register with a skid stage behind it
	assign out_free = ~out_valid_q | ~result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q | (acc & produce & ~cfg_fire);
			skid_valid_q <= 1'b0;
		end else if (acc & produce & ~cfg_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (acc & produce) begin
			skid_q <= res;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a transaction while the output register is empty");

	a_col_in_board: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= w_m1)
		else $error("column position beyond board width");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && last_hit && !cfg_fire) |=> (pos_q == '0 && col_q == '0 && row_q == '0))
		else $error("stream position not cleared after last cell of frame");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !produce && !skid_valid_q && out_free) |=> !out_valid_q)
		else $error("result emitted before the window was filled");

endmodule

// ===== design/lgs_line_cell.sv =====
// one stage of the row delay chain, holds a middle-row and an upper-row bit
module lgs_line_cell (
	input  logic                    clk,
	input  lgs_pkg::lgs_cell_ctrl_t ctrl,
	input  lgs_pkg::lgs_cell_data_t head,
	input  lgs_pkg::lgs_cell_data_t nb,
	output lgs_pkg::lgs_cell_data_t data
);
	import lgs_pkg::*;

	lgs_cell_data_t data_q;

	// the stage at width-1 takes the new column, the others take their neighbor
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			data_q <= ctrl.load ? head : nb;
		end
	end

	assign data = data_q;

endmodule

// ===== design/lgs_window.sv =====
// 3x3 window register, neighbor count and b3/s23 rule
module lgs_window (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lgs_pkg::lgs_win_ctrl_t ctrl,
	input  logic [2:0]             col,
	output logic [lgs_pkg::CNT_W-1:0] live_neighbors,
	output logic                   next_alive
);
	import lgs_pkg::*;

	logic [WIN_W-1:0] win_q;
	logic [WIN_W-1:0] win;
	logic [WIN_W-1:0] ring;
	logic [CNT_W-1:0] sum;

	// each row has dead cells beyond both of its ends
	assign win  = ctrl.row_start ? {3'b000, win_q[WIN_W-1:3]} : {col, win_q[WIN_W-1:3]};
	assign ring = win & 9'h1EF;

	always_comb begin
		sum = '0;
		for (int i = 0; i < WIN_W; i++) begin
			sum = sum + CNT_W'(ring[i]);
		end
	end

	assign live_neighbors = sum;
	assign next_alive = (sum == CNT_W'(BIRTH_COUNT)) ||
		(win[4] && (sum == CNT_W'(SURVIVE_COUNT)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (ctrl.clear) begin
			win_q <= '0;
		end else if (ctrl.advance) begin
			win_q <= ctrl.row_start ? {col, 6'b000000} : win;
		end
	end

endmodule
